>>> sv/csp_pkg.sv
// Types and constants shared by the closest sorted pairs block.
package csp_pkg;

    localparam logic [31:0] SIGN_BIAS = 32'h8000_0000;
    localparam logic [31:0] GAP_INIT  = 32'hFFFF_FFFF;

    typedef struct packed {
        logic signed [31:0] value;
        logic               final_value;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] lower_value;
        logic signed [31:0] higher_value;
        logic               pair_valid;
        logic               final_pair;
        logic               values_dropped;
    } out_item_t;

    typedef struct packed {
        logic        a_gt_b;
        logic        gap_lt;
        logic        gap_eq;
        logic [31:0] gap;
    } alu_res_t;

endpackage

>>> sv/csp_mem.sv
// Value store with one write port and one registered read port.
module csp_mem
    import csp_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [31:0]   wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [31:0]   rd_data
);

    logic [31:0] mem_reg [DEPTH];
    logic [31:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> sv/csp_alu.sv
// Shared subtract and compare unit for sorting and gap scanning.
module csp_alu
    import csp_pkg::*;
(
    input  logic [31:0] a,
    input  logic [31:0] b,
    input  logic [31:0] min_gap,
    output alu_res_t    res
);

    logic [32:0] diff;

    always_comb begin
        diff       = {1'b0, a} - {1'b0, b};
        res.gap    = diff[31:0];
        res.a_gt_b = !diff[32] && (diff[31:0] != 32'd0);
        res.gap_lt = diff[31:0] < min_gap;
        res.gap_eq = diff[31:0] == min_gap;
    end

endmodule

>>> sv/closest_sorted_pairs.sv
// Top level: loads a set, sorts it in place and emits the closest neighbouring pairs.
// Loading takes one item per cycle while ready is high; ready falls after the closing item.
// The insertion sort works through the n held values in place, one compare each step.
// A gap scan finds the smallest gap; the emit scan then waits on any output stalls.
// Ready returns once the final result of the set sits in the output register.
// Reset is synchronous and active low; it empties the set and the output register.
module closest_sorted_pairs
    import csp_pkg::*;
#(
    parameter int MAX_VALUES = 64
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    localparam int AW = $clog2(MAX_VALUES);
    localparam int CW = $clog2(MAX_VALUES + 1);
    localparam logic [CW-1:0] CAP = CW'(MAX_VALUES);
    localparam logic [CW-1:0] ONE = CW'(1);
    localparam logic [CW-1:0] TWO = CW'(2);

    localparam logic [3:0] S_LOAD  = 4'd0;
    localparam logic [3:0] S_KEY   = 4'd1;
    localparam logic [3:0] S_KEYL  = 4'd2;
    localparam logic [3:0] S_CMP   = 4'd3;
    localparam logic [3:0] S_PUT   = 4'd4;
    localparam logic [3:0] S_MIN0  = 4'd5;
    localparam logic [3:0] S_MIN1  = 4'd6;
    localparam logic [3:0] S_MINL  = 4'd7;
    localparam logic [3:0] S_EMIT0 = 4'd8;
    localparam logic [3:0] S_EMIT1 = 4'd9;
    localparam logic [3:0] S_EMITL = 4'd10;
    localparam logic [3:0] S_EMPTY = 4'd11;

    logic [3:0]    state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] j_reg, j_next;
    logic [CW-1:0] p_reg, p_next;
    logic [CW-1:0] last_reg, last_next;
    logic          ovf_reg, ovf_next;
    logic [31:0]   min_reg, min_next;
    logic [31:0]   opnd_reg, opnd_next;
    logic          m_valid_reg, m_valid_next;
    out_item_t     m_item_reg, m_item_next;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [31:0]   wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [31:0]   rd_data;
    alu_res_t      alu;
    logic          out_free;
    logic [CW-1:0] n_fin;
    logic [CW-1:0] i_inc;
    logic [CW-1:0] i_dec;
    logic [CW-1:0] j_dec2;
    logic [CW-1:0] p_inc;

    csp_mem #(
        .DEPTH (MAX_VALUES),
        .AW    (AW)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    csp_alu u_alu (
        .a       (rd_data),
        .b       (opnd_reg),
        .min_gap (min_reg),
        .res     (alu)
    );

    assign s_ready  = (state_reg == S_LOAD);
    assign m_valid  = m_valid_reg;
    assign m_item   = m_item_reg;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        p_next       = p_reg;
        last_next    = last_reg;
        ovf_next     = ovf_reg;
        min_next     = min_reg;
        opnd_next    = opnd_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_item_next  = m_item_reg;
        wr_en        = 1'b0;
        wr_addr      = '0;
        wr_data      = '0;
        rd_en        = 1'b0;
        rd_addr      = '0;
        n_fin        = (cnt_reg != CAP) ? cnt_reg + ONE : cnt_reg;
        i_inc        = i_reg + ONE;
        i_dec        = i_reg - ONE;
        j_dec2       = j_reg - TWO;
        p_inc        = p_reg + ONE;

        case (state_reg)
            S_LOAD: begin
                if (s_valid) begin
                    if (cnt_reg != CAP) begin
                        wr_en    = 1'b1;
                        wr_addr  = cnt_reg[AW-1:0];
                        wr_data  = {~s_item.value[31], s_item.value[30:0]};
                        cnt_next = cnt_reg + ONE;
                    end else begin
                        ovf_next = 1'b1;
                    end
                    if (s_item.final_value) begin
                        if (n_fin < TWO) begin
                            state_next = S_EMPTY;
                        end else begin
                            i_next     = ONE;
                            state_next = S_KEY;
                        end
                    end
                end
            end
            S_KEY: begin
                rd_en      = 1'b1;
                rd_addr    = i_reg[AW-1:0];
                state_next = S_KEYL;
            end
            S_KEYL: begin
                opnd_next  = rd_data;
                j_next     = i_reg;
                rd_en      = 1'b1;
                rd_addr    = i_dec[AW-1:0];
                state_next = S_CMP;
            end
            S_CMP: begin
                wr_en   = 1'b1;
                wr_addr = j_reg[AW-1:0];
                if (alu.a_gt_b) begin
                    wr_data = rd_data;
                    j_next  = j_reg - ONE;
                    if (j_reg == ONE) begin
                        state_next = S_PUT;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = j_dec2[AW-1:0];
                    end
                end else begin
                    wr_data    = opnd_reg;
                    i_next     = i_inc;
                    state_next = (i_inc == cnt_reg) ? S_MIN0 : S_KEY;
                end
            end
            S_PUT: begin
                wr_en      = 1'b1;
                wr_addr    = j_reg[AW-1:0];
                wr_data    = opnd_reg;
                i_next     = i_inc;
                state_next = (i_inc == cnt_reg) ? S_MIN0 : S_KEY;
            end
            S_MIN0, S_EMIT0: begin
                rd_en      = 1'b1;
                rd_addr    = '0;
                state_next = (state_reg == S_MIN0) ? S_MIN1 : S_EMIT1;
            end
            S_MIN1, S_EMIT1: begin
                opnd_next  = rd_data;
                rd_en      = 1'b1;
                rd_addr    = ONE[AW-1:0];
                p_next     = ONE;
                state_next = (state_reg == S_MIN1) ? S_MINL : S_EMITL;
            end
            S_MINL: begin
                if (alu.gap_lt) begin
                    min_next  = alu.gap;
                    last_next = p_reg;
                end else if (alu.gap_eq) begin
                    last_next = p_reg;
                end
                opnd_next = rd_data;
                if (p_inc == cnt_reg) begin
                    state_next = S_EMIT0;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = p_inc[AW-1:0];
                    p_next  = p_inc;
                end
            end
            S_EMITL: begin
                if (!alu.gap_eq || out_free) begin
                    if (alu.gap_eq) begin
                        m_valid_next                = 1'b1;
                        m_item_next.lower_value     = {~opnd_reg[31], opnd_reg[30:0]};
                        m_item_next.higher_value    = {~rd_data[31], rd_data[30:0]};
                        m_item_next.pair_valid      = 1'b1;
                        m_item_next.final_pair      = (p_reg == last_reg);
                        m_item_next.values_dropped  = ovf_reg;
                    end
                    opnd_next = rd_data;
                    if (p_reg == last_reg) begin
                        cnt_next   = '0;
                        ovf_next   = 1'b0;
                        min_next   = GAP_INIT;
                        state_next = S_LOAD;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = p_inc[AW-1:0];
                        p_next  = p_inc;
                    end
                end
            end
            S_EMPTY: begin
                if (out_free) begin
                    m_valid_next               = 1'b1;
                    m_item_next.lower_value    = '0;
                    m_item_next.higher_value   = '0;
                    m_item_next.pair_valid     = 1'b0;
                    m_item_next.final_pair     = 1'b1;
                    m_item_next.values_dropped = ovf_reg;
                    cnt_next                   = '0;
                    ovf_next                   = 1'b0;
                    min_next                   = GAP_INIT;
                    state_next                 = S_LOAD;
                end
            end
            default: begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_LOAD;
            cnt_reg     <= '0;
            i_reg       <= '0;
            j_reg       <= '0;
            p_reg       <= '0;
            last_reg    <= '0;
            ovf_reg     <= 1'b0;
            min_reg     <= GAP_INIT;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            i_reg       <= i_next;
            j_reg       <= j_next;
            p_reg       <= p_next;
            last_reg    <= last_next;
            ovf_reg     <= ovf_next;
            min_reg     <= min_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        opnd_reg   <= opnd_next;
        m_item_reg <= m_item_next;
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CAP)
        else $error("stored count exceeds capacity");

    a_ovf_full: assert property (@(posedge aclk) disable iff (!aresetn)
        ovf_reg |-> (cnt_reg == CAP))
        else $error("overflow flag set while store not full");

    a_gap_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_LOAD) |-> (min_reg == GAP_INIT))
        else $error("smallest gap not cleared while loading");

    a_nonfinal_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_item_reg.final_pair) |-> (state_reg == S_EMITL))
        else $error("non-final result pending outside the emit scan");
`endif

endmodule
